// ===== src/dtv_pkg.sv =====
// ----------------------------------------------------------------------------
// dtv_pkg: shared types and helpers for the date-time string validator
// Status codes, the per-value parse state and small digit arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dtv_pkg;

    // Default kept length of a value
    localparam int DTV_MAX_LENGTH = 26;

    // Fixed field widths
    localparam int POS_W    = 5;
    localparam int STEM_LEN = 14;
    localparam int OFF_LEN  = 4;
    localparam int RUN_W    = 3;

    // Latest end index allowed when a fraction is present
    localparam int FRAC_END_MAX = 21;

    // Characters of interest
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Result status codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_TOO_LONG   = 4'd1,
        ST_BAD_CHAR   = 4'd2,
        ST_TWO_DOTS   = 4'd3,
        ST_TWO_SIGNS  = 4'd4,
        ST_SPACE      = 4'd5,
        ST_OFFSET     = 4'd6,
        ST_FRACTION   = 4'd7,
        ST_COMPONENTS = 4'd8,
        ST_DATE       = 4'd9,
        ST_TIME       = 4'd10
    } status_t;

    // Running state of one value; positions are index+1, zero meaning none
    typedef struct packed {
        logic [POS_W-1:0]          position;
        logic [POS_W-1:0]          dot_position;
        logic [POS_W-1:0]          sign_position;
        logic [POS_W-1:0]          stem_digits;
        logic                      stem_open;
        logic                      pending_space;
        status_t                   first_error;
        logic [POS_W-1:0]          first_error_position;
        logic [STEM_LEN-1:0][3:0]  stem_digit;
        logic [OFF_LEN-1:0][3:0]   off_digit;
        logic [RUN_W-1:0]          off_run;
        logic                      dropped;
        logic                      frac_digit;
    } dtv_state_t;

    // State at the start of a value
    function automatic dtv_state_t dtv_clear();
        dtv_state_t s;
        s           = '0;
        s.stem_open = 1'b1;
        return s;
    endfunction

    // Two decimal digits to a value, tens first
    function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] ones);
        logic [6:0] t;
        t = {3'b000, tens};
        return (t << 3) + (t << 1) + {3'b000, ones};
    endfunction

    // Days in a month of 1 to 12
    function automatic logic [4:0] days_in_month(input logic [6:0] mo, input logic leap);
        logic [4:0] dim;
        case (mo) inside
            7'd4, 7'd6, 7'd9, 7'd11: dim = 5'd30;
            7'd2:                    dim = leap ? 5'd29 : 5'd28;
            default:                 dim = 5'd31;
        endcase
        return dim;
    endfunction

endpackage

`default_nettype wire

// ===== src/dtv_parse.sv =====
// ----------------------------------------------------------------------------
// dtv_parse: per-character state update
// Holds the running state of one value and works out the state after the
// character in the input register; clears back to start on the last request.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_parse #(
    parameter int MAX_LENGTH = dtv_pkg::DTV_MAX_LENGTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        character,
    input  wire logic              last,
    input  wire logic              empty_req,
    output dtv_pkg::dtv_state_t    state_next
);
    import dtv_pkg::*;

    localparam logic [POS_W:0] MAX_POS = (POS_W+1)'(MAX_LENGTH);

    dtv_state_t state_reg;
    dtv_state_t s;
    logic [POS_W-1:0] p;
    logic             is_digit;
    logic [3:0]       d;
    logic [POS_W:0]   off_pos;

    // Take one character
    always_comb
    begin
        s        = state_reg;
        p        = state_reg.position;
        is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
        d        = character[3:0];
        off_pos  = {1'b0, state_reg.sign_position} + {{(POS_W+1-RUN_W){1'b0}}, state_reg.off_run};
        if (!empty_req)
        begin
            if ({1'b0, p} >= MAX_POS)
            begin
                s.dropped = 1'b1;
            end
            else
            begin
                s.position = p + 1'b1;
                if (state_reg.first_error == ST_OK)
                begin
                    s.pending_space = 1'b0;
                    if (state_reg.pending_space && (character != CH_NUL))
                    begin
                        // space not at the end
                        s.first_error          = ST_SPACE;
                        s.first_error_position = p - 1'b1;
                    end
                    else if (is_digit)
                    begin
                        if (state_reg.stem_open)
                        begin
                            s.stem_digits = p + 1'b1;
                            if (p < POS_W'(STEM_LEN))
                                s.stem_digit[p[3:0]] = d;
                        end
                        if ((state_reg.dot_position != '0) && (p == state_reg.dot_position))
                            s.frac_digit = 1'b1;
                        if ((state_reg.sign_position != '0) && (state_reg.off_run < RUN_W'(OFF_LEN))
                            && ({1'b0, p} == off_pos))
                        begin
                            s.off_digit[state_reg.off_run[1:0]] = d;
                            s.off_run = state_reg.off_run + 1'b1;
                        end
                    end
                    else
                    begin
                        s.stem_open = 1'b0;
                        if (character == CH_DOT)
                        begin
                            if (state_reg.dot_position != '0)
                            begin
                                s.first_error          = ST_TWO_DOTS;
                                s.first_error_position = p;
                            end
                            else
                                s.dot_position = p + 1'b1;
                        end
                        else if ((character == CH_PLUS) || (character == CH_MINUS))
                        begin
                            if (state_reg.sign_position != '0)
                            begin
                                s.first_error          = ST_TWO_SIGNS;
                                s.first_error_position = p;
                            end
                            else
                                s.sign_position = p + 1'b1;
                        end
                        else if (character == CH_SPACE)
                        begin
                            if (!p[0])
                            begin
                                s.first_error          = ST_SPACE;
                                s.first_error_position = p;
                            end
                            else if (({1'b0, p} + 1'b1) < MAX_POS)
                                s.pending_space = 1'b1;
                        end
                        else
                        begin
                            s.first_error          = ST_BAD_CHAR;
                            s.first_error_position = p;
                        end
                    end
                end
            end
        end
    end

    assign state_next = s;

    // State register; back to start after each value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dtv_clear();
        else if (step)
            state_reg <= last ? dtv_clear() : s;
    end

endmodule

`default_nettype wire

// ===== src/dtv_check.sv =====
// ----------------------------------------------------------------------------
// dtv_check: end-of-value checks
// Turns the final state of a value into its status and error position.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_check (
    input  wire dtv_pkg::dtv_state_t st,
    output dtv_pkg::status_t         status,
    output logic [4:0]               error_position
);
    import dtv_pkg::*;

    logic [6:0] mo, dy, hr, mi, se, off_hr, off_mi;
    logic [4:0] dim;
    logic       end_ok, leap, lo_div4, lo_zero, hi_div4;
    logic [1:0] lo_mod, hi_mod;

    // Component values with defaults for omitted fields
    always_comb
    begin
        mo     = (st.stem_digits >= 5'd6)  ? two_digit(st.stem_digit[4],  st.stem_digit[5])  : 7'd1;
        dy     = (st.stem_digits >= 5'd8)  ? two_digit(st.stem_digit[6],  st.stem_digit[7])  : 7'd1;
        hr     = (st.stem_digits >= 5'd10) ? two_digit(st.stem_digit[8],  st.stem_digit[9])  : 7'd0;
        mi     = (st.stem_digits >= 5'd12) ? two_digit(st.stem_digit[10], st.stem_digit[11]) : 7'd0;
        se     = (st.stem_digits >= 5'd14) ? two_digit(st.stem_digit[12], st.stem_digit[13]) : 7'd0;
        off_hr = two_digit(st.off_digit[0], st.off_digit[1]);
        off_mi = two_digit(st.off_digit[2], st.off_digit[3]);
        // year mod 4 from two digits: (10a+b) mod 4 = (2a+b) mod 4
        lo_mod  = {st.stem_digit[2][0], 1'b0} + st.stem_digit[3][1:0];
        hi_mod  = {st.stem_digit[0][0], 1'b0} + st.stem_digit[1][1:0];
        lo_div4 = (lo_mod == 2'd0);
        hi_div4 = (hi_mod == 2'd0);
        lo_zero = (st.stem_digit[2] == 4'd0) && (st.stem_digit[3] == 4'd0);
        leap    = lo_div4 && (!lo_zero || hi_div4);
        dim     = days_in_month(mo, leap);
        end_ok  = (st.sign_position != '0) ? (st.sign_position <= 5'(FRAC_END_MAX + 2))
                                           : (st.position <= 5'(FRAC_END_MAX + 1));
    end

    // Checks in priority order
    always_comb
    begin
        if (st.position == '0)
            status = ST_OK;
        else if (st.first_error != ST_OK)
            status = st.first_error;
        else if ((st.sign_position != '0) &&
                 ((st.off_run < 3'(OFF_LEN)) || (off_hr >= 7'd24) || (off_mi >= 7'd60)))
            status = ST_OFFSET;
        else if ((st.dot_position != '0) &&
                 !((st.stem_digits == 5'(STEM_LEN)) && (st.dot_position == 5'(STEM_LEN + 1))
                   && st.frac_digit && end_ok))
            status = ST_FRACTION;
        else if ((st.stem_digits < 5'd4) || (st.stem_digits > 5'(STEM_LEN)) || st.stem_digits[0])
            status = ST_COMPONENTS;
        else if ((mo < 7'd1) || (mo > 7'd12) || (dy < 7'd1) || (dy > {2'b00, dim}))
            status = ST_DATE;
        else if ((hr >= 7'd24) || (mi >= 7'd60) || (se >= 7'd60))
            status = ST_TIME;
        else if (st.dropped)
            status = ST_TOO_LONG;
        else
            status = ST_OK;
    end

    // Position only for character-level errors
    assign error_position = ((status == ST_BAD_CHAR) || (status == ST_TWO_DOTS) ||
                             (status == ST_TWO_SIGNS) || (status == ST_SPACE))
                            ? st.first_error_position : 5'd0;

endmodule

`default_nettype wire

// ===== src/datetime_string_validator_core.sv =====
// A result is registered: its last character passes the input register, then the result register.
// Throughput: one character per cycle; the state update and checks form one
// pass between the input register and the result register.
// A result held at the output stalls the input only when the next value ends.
// Reset (rst_n low, asynchronous) empties both registers and clears the
// running state to the start of a value.
// ----------------------------------------------------------------------------
// datetime_string_validator_core: streaming date-time string validator
// Takes one character per request and gives one status request per value.
// ----------------------------------------------------------------------------
`default_nettype none

module datetime_string_validator_core #(
    parameter int MAX_LENGTH = dtv_pkg::DTV_MAX_LENGTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tlast,
    input  wire logic        s_axis_tuser,   // [0] empty_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [3:0] status, [8:4] error_position
);
    import dtv_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       in_empty_reg;
    logic       out_valid_reg;
    status_t    out_status_reg;
    logic [4:0] out_pos_reg;

    logic       out_free;
    logic       advance;
    dtv_state_t state_next;
    status_t    status;
    logic [4:0] error_position;

    // Flow control: a non-last character never waits on the output
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg  <= s_axis_tdata;
            in_last_reg  <= s_axis_tlast;
            in_empty_reg <= s_axis_tuser;
        end
    end

    dtv_parse #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .character  (in_char_reg),
        .last       (in_last_reg),
        .empty_req  (in_empty_reg),
        .state_next (state_next)
    );

    dtv_check u_check (
        .st             (state_next),
        .status         (status),
        .error_position (error_position)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_status_reg <= status;
            out_pos_reg    <= error_position;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_pos_reg, out_status_reg};

    // A new result only follows a last character taken through
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result raised without a last character");

    // A last character never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg && out_valid_reg) |-> m_axis_tready)
        else $error("waiting result overwritten");

    // Error position only reported for character-level errors
    a_pos_only_char_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_pos_reg != 5'd0)) |->
        ((out_status_reg == ST_BAD_CHAR) || (out_status_reg == ST_TWO_DOTS) ||
         (out_status_reg == ST_TWO_SIGNS) || (out_status_reg == ST_SPACE)))
        else $error("error position with a non-character status");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the date-time string validator core
// Streams date-time strings one character per request, mostly well-formed
// values with random content and some noise, and predicts the status of each
// value in the bench. Every status request is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

    import dtv_pkg::*;

    localparam int KEEP_LEN   = DTV_MAX_LENGTH;
    localparam int CHAR_GOAL  = 1600;

    // One character request as presented to the block
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       empty;
        logic       hold;     // wait for all statuses before presenting
    } char_req_t;

    // Expected status request
    typedef struct {
        status_t    status;
        logic [4:0] err_at;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] character
    logic        s_axis_tlast;
    logic        s_axis_tuser;    // [0] empty_req
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // [3:0] status, [8:4] error_position

    datetime_string_validator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    char_req_t   pending_chars[$];
    verdict_t    expected_status[$];
    logic [7:0]  value_chars[$];
    int          char_count;
    int          errors;
    logic        s_fire;

    // Parse state of the value in flight
    logic [4:0]  pos_cnt, dot_pos, sign_pos, stem_cnt, err_pos_q, off_run;
    logic        stem_live, space_wait, dropped_q, frac_seen;
    status_t     err_code;
    logic [13:0] year_acc;
    logic [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
    logic [6:0]  off_hour_acc, off_min_acc;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Status prediction
    // ------------------------------------------------------------------------

    function automatic void clear_parse();
        pos_cnt      = '0;
        dot_pos      = '0;
        sign_pos     = '0;
        stem_cnt     = '0;
        err_pos_q    = '0;
        off_run      = '0;
        stem_live    = 1'b1;
        space_wait   = 1'b0;
        dropped_q    = 1'b0;
        frac_seen    = 1'b0;
        err_code     = ST_OK;
        year_acc     = '0;
        month_acc    = '0;
        day_acc      = '0;
        hour_acc     = '0;
        minute_acc   = '0;
        second_acc   = '0;
        off_hour_acc = '0;
        off_min_acc  = '0;
    endfunction

    // First character-level error wins
    function automatic void raise_error(status_t code, int at);
        if (err_code == ST_OK)
        begin
            err_code  = code;
            err_pos_q = at[4:0];
        end
    endfunction

    function automatic int month_length(int yr, int mo);
        int dim;
        case (mo)
            4, 6, 9, 11: dim = 30;
            2:           dim = ((yr % 4 == 0) && (yr % 100 != 0 || yr % 400 == 0)) ? 29 : 28;
            default:     dim = 31;
        endcase
        return dim;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        int  p;
        int  d;
        bit  skip;
        p    = pos_cnt;
        skip = 1'b0;
        if (p >= KEEP_LEN)
            dropped_q = 1'b1;
        else
        begin
            pos_cnt = 5'(p + 1);
            if (err_code != ST_OK)
                skip = 1'b1;
            else if (space_wait)
            begin
                // a pending space is only forgiven by a following NUL
                space_wait = 1'b0;
                if (c != CH_NUL)
                begin
                    raise_error(ST_SPACE, p - 1);
                    skip = 1'b1;
                end
            end
            if (!skip && c >= CH_ZERO && c <= CH_NINE)
            begin
                d = int'(c - CH_ZERO);
                if (stem_live)
                begin
                    stem_cnt = 5'(p + 1);
                    if (p < 4)       year_acc   = 14'(year_acc * 10 + d);
                    else if (p < 6)  month_acc  = 7'(month_acc * 10 + d);
                    else if (p < 8)  day_acc    = 7'(day_acc * 10 + d);
                    else if (p < 10) hour_acc   = 7'(hour_acc * 10 + d);
                    else if (p < 12) minute_acc = 7'(minute_acc * 10 + d);
                    else if (p < 14) second_acc = 7'(second_acc * 10 + d);
                end
                if (dot_pos != 0 && p == int'(dot_pos))
                    frac_seen = 1'b1;
                if (sign_pos != 0 && off_run < 4 && p == int'(sign_pos) + int'(off_run))
                begin
                    if (off_run < 2)
                        off_hour_acc = 7'(off_hour_acc * 10 + d);
                    else
                        off_min_acc = 7'(off_min_acc * 10 + d);
                    off_run = off_run + 5'd1;
                end
            end
            else if (!skip)
            begin
                stem_live = 1'b0;
                if (c == CH_DOT)
                begin
                    if (dot_pos != 0) raise_error(ST_TWO_DOTS, p);
                    else              dot_pos = 5'(p + 1);
                end
                else if (c == CH_PLUS || c == CH_MINUS)
                begin
                    if (sign_pos != 0) raise_error(ST_TWO_SIGNS, p);
                    else               sign_pos = 5'(p + 1);
                end
                else if (c == CH_SPACE)
                begin
                    if ((p & 1) == 0)        raise_error(ST_SPACE, p);
                    else if (p + 1 < KEEP_LEN) space_wait = 1'b1;
                end
                else
                    raise_error(ST_BAD_CHAR, p);
            end
        end
    endfunction

    // Status of the completed value
    function automatic status_t judge_value();
        int end_idx;
        int mo, dy, hr, mi, se;
        if (pos_cnt == 0)
            return ST_OK;
        if (err_code != ST_OK)
            return err_code;
        if (sign_pos != 0)
        begin
            if (off_run < 4 || off_hour_acc >= 24 || off_min_acc >= 60)
                return ST_OFFSET;
            end_idx = int'(sign_pos) - 2;
        end
        else
            end_idx = int'(pos_cnt) - 1;
        if (dot_pos != 0)
        begin
            if (!(stem_cnt == 14 && dot_pos == 15 && frac_seen && end_idx <= FRAC_END_MAX))
                return ST_FRACTION;
        end
        if (stem_cnt < 4 || stem_cnt > 14 || stem_cnt[0])
            return ST_COMPONENTS;
        mo = (stem_cnt >= 6)  ? int'(month_acc)  : 1;
        dy = (stem_cnt >= 8)  ? int'(day_acc)    : 1;
        hr = (stem_cnt >= 10) ? int'(hour_acc)   : 0;
        mi = (stem_cnt >= 12) ? int'(minute_acc) : 0;
        se = (stem_cnt >= 14) ? int'(second_acc) : 0;
        if (mo < 1 || mo > 12 || dy < 1 || dy > month_length(int'(year_acc), mo))
            return ST_DATE;
        if (hr >= 24 || mi >= 60 || se >= 60)
            return ST_TIME;
        return dropped_q ? ST_TOO_LONG : ST_OK;
    endfunction

    // Accepted character request: update the parse and queue a status on last
    function automatic void take_request(char_req_t rq);
        verdict_t v;
        if (!rq.empty)
            parse_char(rq.ch);
        if (rq.last)
        begin
            v.status = judge_value();
            v.err_at = (v.status >= ST_BAD_CHAR && v.status <= ST_SPACE) ? err_pos_q : 5'd0;
            expected_status.push_back(v);
            clear_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    function automatic void add_num(int v, int digits);
        int div;
        div = 1;
        for (int i = 1; i < digits; i++)
            div = div * 10;
        for (int i = 0; i < digits; i++)
        begin
            value_chars.push_back(8'(int'(CH_ZERO) + (v / div) % 10));
            div = div / 10;
        end
    endfunction

    function automatic logic [7:0] odd_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_DOT;
            1:       c = CH_PLUS;
            2:       c = CH_MINUS;
            3:       c = CH_SPACE;
            4:       c = CH_NUL;
            5:       c = 8'h3a;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'(int'(CH_ZERO) + $urandom_range(0, 9));
        else if (r < 7)
            return odd_char();
        return 8'($urandom_range(0, 255));
    endfunction

    // Turn the built string into requests, with blank requests scattered in
    function automatic void emit_value(bit hold);
        char_req_t rq;
        int        n;
        bit        blank_end;
        bit        first;
        n         = value_chars.size();
        blank_end = (n == 0) || ($urandom_range(0, 9) == 0);
        first     = hold;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                rq = '{ch: 8'($urandom_range(0, 255)), last: 1'b0, empty: 1'b1, hold: first};
                pending_chars.push_back(rq);
                first = 1'b0;
            end
            rq = '{ch: value_chars[i], last: (i == n - 1) && !blank_end, empty: 1'b0,
                   hold: first};
            pending_chars.push_back(rq);
            first      = 1'b0;
            char_count = char_count + 1;
        end
        if (blank_end)
        begin
            rq = '{ch: 8'($urandom_range(0, 255)), last: 1'b1, empty: 1'b1, hold: first};
            pending_chars.push_back(rq);
            char_count = char_count + 1;
        end
        value_chars.delete();
    endfunction

    // Mostly plausible date-time strings, with boundary values and faults mixed in
    function automatic void build_datetime();
        int stem_len, yr, mo, dy, hr, mi, se, oh, om, n, k, target;
        if ($urandom_range(0, 9) == 0)
            stem_len = $urandom_range(1, 14);
        else
            stem_len = 4 + 2 * $urandom_range(0, 5);
        case ($urandom_range(0, 15))
            0:       yr = 1900;
            1:       yr = 2000;
            2:       yr = 2024;
            3:       yr = 2100;
            4:       yr = ($urandom_range(0, 1) == 0) ? 0 : 9999;
            default: yr = $urandom_range(0, 9999);
        endcase
        mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) :
             (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99));
        case ($urandom_range(0, 19))
            0:       dy = 0;
            1:       dy = month_length(yr, (mo >= 1 && mo <= 12) ? mo : 1) + 1;
            2:       dy = $urandom_range(0, 99);
            3:       dy = month_length(yr, (mo >= 1 && mo <= 12) ? mo : 1);
            default: dy = $urandom_range(1, month_length(yr, (mo >= 1 && mo <= 12) ? mo : 1));
        endcase
        hr = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 23) : $urandom_range(24, 99);
        mi = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        se = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
        add_num(yr, 4);
        add_num(mo, 2);
        add_num(dy, 2);
        add_num(hr, 2);
        add_num(mi, 2);
        add_num(se, 2);
        while (value_chars.size() > stem_len)
            void'(value_chars.pop_back());

        // fraction
        if ((stem_len == 14 && $urandom_range(0, 9) < 4) || $urandom_range(0, 19) == 0)
        begin
            value_chars.push_back(CH_DOT);
            k = $urandom_range(0, 9);
            n = (k == 0) ? 0 : (k == 1) ? $urandom_range(7, 9) : $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                value_chars.push_back(8'(int'(CH_ZERO) + $urandom_range(0, 9)));
        end

        // offset
        if ($urandom_range(0, 9) < 4)
        begin
            value_chars.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
            oh = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 23) : $urandom_range(24, 99);
            om = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 59) : $urandom_range(60, 99);
            add_num(oh * 100 + om, 4);
            if ($urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(0, 3);
                while (value_chars.size() > 0 && n < 4)
                begin
                    void'(value_chars.pop_back());
                    n = n + 1;
                end
            end
        end

        // trailing space, space then NUL, or overlong tail
        k = $urandom_range(0, 19);
        if (k < 2)
            value_chars.push_back(CH_SPACE);
        else if (k == 2)
        begin
            value_chars.push_back(CH_SPACE);
            value_chars.push_back(CH_NUL);
        end
        else if (k < 5)
        begin
            target = $urandom_range(KEEP_LEN + 1, KEEP_LEN + 5);
            while (value_chars.size() < target)
                value_chars.push_back(($urandom_range(0, 2) == 0) ? odd_char() :
                                      8'(int'(CH_ZERO) + $urandom_range(0, 9)));
        end

        // occasional fault
        if (value_chars.size() > 0 && $urandom_range(0, 9) == 0)
            value_chars[$urandom_range(0, value_chars.size() - 1)] = odd_char();
    endfunction

    function automatic void build_noise();
        int n;
        n = $urandom_range(0, 31);
        for (int i = 0; i < n; i++)
            value_chars.push_back(any_char());
    endfunction

    // ------------------------------------------------------------------------
    // Request side: driver and idle pattern
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    int  tx_gap_left;
    int  tx_run_left;
    bit  tx_calm;

    always @(negedge clk)
    begin : drive_proc
        char_req_t nxt;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !s_fire)
        begin
            // request still waiting for acceptance
        end
        else if (tx_gap_left != 0)
        begin
            tx_gap_left = tx_gap_left - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_chars.size() != 0 &&
                 !(pending_chars[0].hold && expected_status.size() != 0))
        begin
            nxt = pending_chars.pop_front();
            s_axis_tdata  <= nxt.ch;
            s_axis_tlast  <= nxt.last;
            s_axis_tuser  <= nxt.empty;
            s_axis_tvalid <= 1'b1;
            if (tx_run_left == 0)
            begin
                tx_calm     = ($urandom_range(0, 3) == 0);
                tx_run_left = $urandom_range(20, 200);
            end
            tx_run_left = tx_run_left - 1;
            tx_gap_left = tx_calm ? 0 : pick_gap();
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Status side: ready pattern
    // ------------------------------------------------------------------------

    int  rx_stall_left;
    int  rx_run_left;
    bit  rx_calm;

    always @(negedge clk)
    begin : sink_proc
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (rx_run_left == 0)
            begin
                rx_calm     = ($urandom_range(0, 3) == 0);
                rx_run_left = $urandom_range(50, 500);
            end
            rx_run_left = rx_run_left - 1;
            if (rx_stall_left != 0)
            begin
                rx_stall_left = rx_stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 3) == 0)
                    rx_stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predict on accepted characters, check each status request
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        errors = errors + 1;
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : watch_proc
        verdict_t want;
        s_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (s_fire)
            take_request('{ch: s_axis_tdata, last: s_axis_tlast, empty: s_axis_tuser,
                           hold: 1'b0});
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_status.size() == 0)
                report_mismatch($sformatf("status %0d with none expected", m_axis_tdata[3:0]));
            else
            begin
                want = expected_status.pop_front();
                if (m_axis_tdata[3:0] != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_axis_tdata[3:0], want.status));
                if (m_axis_tdata[8:4] != want.err_at)
                    report_mismatch($sformatf("error position %0d, expected %0d",
                                              m_axis_tdata[8:4], want.err_at));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------

    initial
    begin : run_proc
        int values;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        s_fire        = 1'b0;
        errors        = 0;
        char_count    = 0;
        tx_gap_left   = 0;
        tx_run_left   = 0;
        tx_calm       = 1'b0;
        rx_stall_left = 0;
        rx_run_left   = 0;
        rx_calm       = 1'b0;
        clear_parse();

        // directed: empty value, a bare year, space then NUL, even-index space,
        // second dot, second sign, top-bit byte
        emit_value(1'b0);
        add_num(2000, 4);
        emit_value(1'b0);
        add_num(200, 3);
        value_chars.push_back(CH_SPACE);
        value_chars.push_back(CH_NUL);
        emit_value(1'b0);
        add_num(20, 2);
        value_chars.push_back(CH_SPACE);
        emit_value(1'b0);
        add_num(2, 1);
        value_chars.push_back(CH_DOT);
        value_chars.push_back(CH_DOT);
        emit_value(1'b0);
        add_num(9, 1);
        value_chars.push_back(CH_PLUS);
        value_chars.push_back(CH_MINUS);
        emit_value(1'b0);
        value_chars.push_back(8'hff);
        emit_value(1'b0);

        // random values; now and then the sender drains the statuses first
        values = 0;
        while (char_count < CHAR_GOAL)
        begin
            if ($urandom_range(0, 9) < 8)
                build_datetime();
            else
                build_noise();
            emit_value(values % 150 == 0);
            values = values + 1;
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_chars.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
src/dtv_pkg.sv
src/dtv_parse.sv
src/dtv_check.sv
src/datetime_string_validator_core.sv
bench/tb_top.sv
